// ----- rtl/fccs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// FAT cluster chain step: shared package
// Item types, register and status codes, and default sizes.
// ----------------------------------------------------------------------------
package fccs_pkg;

  localparam int DEF_WINDOW_BYTES = 2048;
  localparam int DEF_SECTOR_BYTES = 512;

  localparam logic [1:0] FAT_12 = 2'd0;
  localparam logic [1:0] FAT_16 = 2'd1;
  localparam logic [1:0] FAT_32 = 2'd2;

  localparam logic [11:0] EOC_12 = 12'hFF8;
  localparam logic [15:0] EOC_16 = 16'hFFF8;
  localparam logic [27:0] EOC_32 = 28'hFFFFFF8;

  typedef enum logic [2:0] {
    CFG_FAT_TYPE   = 3'd0,
    CFG_CLUS_COUNT = 3'd1,
    CFG_FAT_START  = 3'd2,
    CFG_DATA_START = 3'd3,
    CFG_CLUS_SHIFT = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    STAT_NEXT = 3'd0,
    STAT_EOC  = 3'd1,
    STAT_BAD  = 3'd2,
    STAT_MISS = 3'd3,
    STAT_FILL = 3'd4
  } status_t;

  typedef enum logic {
    FUNC_LOOKUP = 1'b0,
    FUNC_FILL   = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CHECK,
    ST_READ,
    ST_WAIT,
    ST_CLASS,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic        func;
    logic [27:0] cluster;
    logic [10:0] fill_index;
    logic [7:0]  fill_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [27:0] chain_link;
    logic [31:0] sector;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  fat_type;
    logic [28:0] cluster_count;
    logic [31:0] data_start_sector;
    logic [2:0]  cluster_shift;
  } cls_cfg_t;

endpackage
`default_nettype wire

// ----- rtl/fccs_window_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// FAT window memory
// Byte-wide memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module fccs_window_ram
  import fccs_pkg::*;
#(
  parameter int DEPTH = DEF_WINDOW_BYTES,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/fccs_classify.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// FAT entry classifier
// Extracts the entry from the gathered bytes and forms the result item.
// ----------------------------------------------------------------------------
module fccs_classify
  import fccs_pkg::*;
(
  input  wire cls_cfg_t  cfg,
  input  wire logic [31:0] raw,
  input  wire logic        odd,
  output out_item_t        res
);

  logic [15:0] half;
  logic [27:0] entry;
  logic        eoc;
  logic        bad;
  logic [31:0] offs;

  always_comb begin
    half = raw[15:0];
    case (cfg.fat_type)
      FAT_12: begin
        if (odd) begin
          half = half >> 4;
        end
        entry = {16'd0, half[11:0]};
        eoc   = (half[11:0] >= EOC_12);
      end
      FAT_16: begin
        entry = {12'd0, half};
        eoc   = (half >= EOC_16);
      end
      default: begin
        entry = raw[27:0];
        eoc   = (raw[27:0] >= EOC_32);
      end
    endcase
    bad  = (entry < 28'd2) || ({1'b0, entry} >= cfg.cluster_count);
    offs = (32'(entry) - 32'd2) << cfg.cluster_shift;
    res.chain_link = entry;
    if (eoc) begin
      res.status = STAT_EOC;
      res.sector = '0;
    end else if (bad) begin
      res.status = STAT_BAD;
      res.sector = '0;
    end else begin
      res.status = STAT_NEXT;
      res.sector = cfg.data_start_sector + offs;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/fat_cluster_chain_step_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// FAT cluster chain step core
// Follows a FAT12/16/32 cluster chain one link per lookup item from a window
// of the FAT held in an on-chip memory.
// ----------------------------------------------------------------------------
// One item is worked on at a time; the result register lets the next item be
// accepted while a result waits. A fill writes the window memory in the
// decode state. A lookup goes on to the check state, where a window miss ends.
// A hit then reads its entry bytes from the window memory, which yields one
// byte per cycle, and the classify state forms the result. Every item then
// passes the emit state and returns to idle. SECTOR_BYTES must be a power of
// two. On a miss the window base moves to the enclosing sector and the returned
// FAT sector must be loaded with fill items before the lookup is repeated.
module fat_cluster_chain_step_core
  import fccs_pkg::*;
#(
  parameter int WINDOW_BYTES = DEF_WINDOW_BYTES,
  parameter int SECTOR_BYTES = DEF_SECTOR_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_item,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  localparam int AW       = $clog2(WINDOW_BYTES);
  localparam int LOG_UNIT = $clog2(2 * SECTOR_BYTES);
  localparam logic [31:0] UNIT_MASK  = 32'(2 * SECTOR_BYTES - 1);
  localparam logic [32:0] WIN_NIBS   = 33'(2 * WINDOW_BYTES);
  localparam logic [31:0] WIN_BYTES  = 32'(WINDOW_BYTES);

  state_t      state_r, state_nxt;
  in_item_t    in_r;
  logic [1:0]  fat_type_r;
  logic [28:0] clus_count_r;
  logic [31:0] fat_start_r;
  logic [31:0] data_start_r;
  logic [2:0]  clus_shift_r;
  logic [30:0] pos_r, pos_nxt;
  logic [3:0]  width_r, width_nxt;
  logic [31:0] base_r, base_nxt;
  logic        win_valid_r, win_valid_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic        odd_r, odd_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        rd_valid_r, rd_valid_nxt;
  logic [1:0]  rd_slot_r;
  logic [7:0]  bytes_r [4];
  out_item_t   res_r, res_nxt;
  out_item_t   out_r;
  logic        out_valid_r, out_valid_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  logic [32:0]   diff;
  logic [32:0]   span;
  logic          miss;
  logic [1:0]    last_slot;
  cls_cfg_t      cls_cfg;
  out_item_t     cls_res;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign cls_cfg.fat_type          = fat_type_r;
  assign cls_cfg.cluster_count     = clus_count_r;
  assign cls_cfg.data_start_sector = data_start_r;
  assign cls_cfg.cluster_shift     = clus_shift_r;

  assign diff      = 33'(pos_r) - 33'(base_r);
  assign span      = 33'(diff[31:0]) + 33'(width_r);
  assign miss      = !win_valid_r || (32'(pos_r) < base_r) || (span > WIN_NIBS);
  assign last_slot = (fat_type_r == FAT_12 || fat_type_r == FAT_16) ? 2'd1 : 2'd3;
  assign mem_raddr = idx_r + AW'(cnt_r);

  fccs_window_ram #(
    .DEPTH (WINDOW_BYTES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(in_r.fill_index)),
    .wdata (in_r.fill_byte),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fccs_classify u_cls (
    .cfg (cls_cfg),
    .raw ({bytes_r[3], bytes_r[2], bytes_r[1], bytes_r[0]}),
    .odd (odd_r),
    .res (cls_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fat_type_r   <= FAT_16;
      clus_count_r <= '0;
      fat_start_r  <= '0;
      data_start_r <= '0;
      clus_shift_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FAT_TYPE:   fat_type_r   <= cfg_wdata[1:0];
        CFG_CLUS_COUNT: clus_count_r <= cfg_wdata[28:0];
        CFG_FAT_START:  fat_start_r  <= cfg_wdata;
        CFG_DATA_START: data_start_r <= cfg_wdata;
        CFG_CLUS_SHIFT: clus_shift_r <= cfg_wdata[2:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_r      <= '0;
      win_valid_r <= 1'b0;
      cnt_r       <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      win_valid_r <= win_valid_nxt;
      cnt_r       <= cnt_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_item;
    end
    pos_r     <= pos_nxt;
    width_r   <= width_nxt;
    idx_r     <= idx_nxt;
    odd_r     <= odd_nxt;
    res_r     <= res_nxt;
    rd_slot_r <= cnt_r;
    if (rd_valid_r) begin
      bytes_r[rd_slot_r] <= mem_rdata;
    end
    if (state_r == ST_EMIT && (!out_valid_r || out_ready)) begin
      out_r <= res_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    width_nxt     = width_r;
    base_nxt      = base_r;
    win_valid_nxt = win_valid_r;
    idx_nxt       = idx_r;
    odd_nxt       = odd_r;
    cnt_nxt       = cnt_r;
    rd_valid_nxt  = 1'b0;
    res_nxt       = res_r;
    mem_we        = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (in_r.func == FUNC_FILL) begin
          mem_we  = (32'(in_r.fill_index) < WIN_BYTES);
          res_nxt = '{status: STAT_FILL, chain_link: '0, sector: '0};
          state_nxt = ST_EMIT;
        end else begin
          case (fat_type_r)
            FAT_12: begin
              pos_nxt   = {2'b00, in_r.cluster, 1'b0} + {3'b000, in_r.cluster};
              width_nxt = 4'd3;
            end
            FAT_16: begin
              pos_nxt   = {1'b0, in_r.cluster, 2'b00};
              width_nxt = 4'd4;
            end
            default: begin
              pos_nxt   = {in_r.cluster, 3'b000};
              width_nxt = 4'd8;
            end
          endcase
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (miss) begin
          base_nxt      = 32'(pos_r) & ~UNIT_MASK;
          win_valid_nxt = 1'b1;
          res_nxt = '{status: STAT_MISS, chain_link: '0,
                      sector: fat_start_r + (32'(pos_r) >> LOG_UNIT)};
          state_nxt = ST_EMIT;
        end else begin
          idx_nxt   = diff[AW:1];
          odd_nxt   = diff[0];
          cnt_nxt   = '0;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        rd_valid_nxt = 1'b1;
        cnt_nxt      = cnt_r + 2'd1;
        if (cnt_r == last_slot) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_nxt = ST_CLASS;
      end
      ST_CLASS: begin
        res_nxt   = cls_res;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- verif/tb_fat_cluster_chain_step_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FAT cluster chain step core testbench
// Drives lookup and fill items through the valid/ready channels, programs the
// FAT geometry between phases, and checks every result against a scoreboard
// that tracks the FAT window, its base and the register settings. Lookups
// are mostly chain walks: a lookup on a miss, fills for the entry, then a hit.
// ----------------------------------------------------------------------------
module tb_fat_cluster_chain_step_core;
  import fccs_pkg::*;

  localparam int WIN_BYTES     = DEF_WINDOW_BYTES;
  localparam int SEC_BYTES     = DEF_SECTOR_BYTES;
  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 9;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 160;
  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_LIMIT   = 2000;
  localparam int MAX_REPORTS   = 100;
  localparam logic [1:0] FAT_UNUSED = 2'd3;

  class fat_chain_scoreboard;
    logic [7:0]  win_data [WIN_BYTES];
    bit          win_loaded [WIN_BYTES];
    logic [31:0] win_base;
    bit          win_held;
    logic [1:0]  fat_type;
    logic [28:0] clus_count;
    logic [31:0] fat_start;
    logic [31:0] data_start;
    logic [2:0]  clus_shift;
    out_item_t   expected_q [$];
    status_t     last_status;
    logic [27:0] last_entry;
    int          errors;
    int          results_seen;

    function new();
      foreach (win_data[i]) begin
        win_data[i]   = '0;
        win_loaded[i] = 1'b0;
      end
      win_base     = '0;
      win_held     = 1'b0;
      fat_type     = FAT_16;
      clus_count   = '0;
      fat_start    = '0;
      data_start   = '0;
      clus_shift   = '0;
      last_status  = STAT_FILL;
      last_entry   = '0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [31:0] v);
      case (idx)
        CFG_FAT_TYPE:   fat_type   = v[1:0];
        CFG_CLUS_COUNT: clus_count = v[28:0];
        CFG_FAT_START:  fat_start  = v;
        CFG_DATA_START: data_start = v;
        CFG_CLUS_SHIFT: clus_shift = v[2:0];
        default: ;
      endcase
    endfunction

    function int unsigned entry_width();
      if (fat_type == FAT_12) return 3;
      if (fat_type == FAT_16) return 4;
      return 8;
    endfunction

    function int unsigned entry_bytes();
      return (entry_width() == 8) ? 4 : 2;
    endfunction

    function longint unsigned eoc_mark();
      if (fat_type == FAT_12) return EOC_12;
      if (fat_type == FAT_16) return EOC_16;
      return EOC_32;
    endfunction

    function longint unsigned entry_mask();
      if (fat_type == FAT_12) return 64'hFFF;
      if (fat_type == FAT_16) return 64'hFFFF;
      return 64'hFFF_FFFF;
    endfunction

    function longint unsigned nibble_pos(logic [27:0] clus);
      longint unsigned c;
      c = clus;
      return c * entry_width();
    endfunction

    function bit misses(logic [27:0] clus);
      longint unsigned pos;
      pos = nibble_pos(clus);
      return !win_held || pos < win_base ||
             pos - win_base + entry_width() > 2 * WIN_BYTES;
    endfunction

    function int unsigned entry_byte(logic [27:0] clus);
      return int'((nibble_pos(clus) - win_base) >> 1);
    endfunction

    function bit reads_unwritten(logic [27:0] clus);
      int unsigned idx;
      if (misses(clus)) return 1'b0;
      idx = entry_byte(clus);
      for (int k = 0; k < entry_bytes(); k++) begin
        if (!win_loaded[idx + k]) return 1'b1;
      end
      return 1'b0;
    endfunction

    function logic [7:0] win_byte(int unsigned idx);
      if (idx < WIN_BYTES) return win_data[idx];
      return '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(in_item_t it);
      out_item_t       want;
      longint unsigned pos;
      longint unsigned rel;
      int unsigned     idx;
      logic [31:0]     raw;
      logic [27:0]     entry;
      want  = '0;
      entry = '0;
      if (it.func == FUNC_FILL) begin
        if (it.fill_index < WIN_BYTES) begin
          win_data[it.fill_index]   = it.fill_byte;
          win_loaded[it.fill_index] = 1'b1;
        end
        want.status = STAT_FILL;
      end else if (misses(it.cluster)) begin
        pos         = nibble_pos(it.cluster);
        pos         = pos - pos % (2 * SEC_BYTES);
        win_base    = 32'(pos);
        win_held    = 1'b1;
        want.status = STAT_MISS;
        want.sector = fat_start + 32'(pos / (2 * SEC_BYTES));
      end else begin
        rel = nibble_pos(it.cluster) - win_base;
        idx = int'(rel >> 1);
        raw = {win_byte(idx + 3), win_byte(idx + 2), win_byte(idx + 1), win_byte(idx)};
        case (entry_width())
          3: entry = 28'(rel[0] ? raw[15:4] : raw[11:0]);
          4: entry = 28'(raw[15:0]);
          default: entry = raw[27:0];
        endcase
        want.chain_link = entry;
        if (entry >= eoc_mark()) begin
          want.status = STAT_EOC;
        end else if (entry < 2 || entry >= clus_count) begin
          want.status = STAT_BAD;
        end else begin
          want.status = STAT_NEXT;
          want.sector = data_start + ((32'(entry) - 32'd2) << clus_shift);
        end
      end
      last_status = status_t'(want.status);
      last_entry  = entry;
      expected_q.push_back(want);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with no item pending (status %0d)",
                         results_seen, got.status));
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status)
        report($sformatf("result %0d status %0d, expected %0d",
                         results_seen, got.status, want.status));
      if (got.chain_link !== want.chain_link)
        report($sformatf("result %0d chain_link %h, expected %h",
                         results_seen, got.chain_link, want.chain_link));
      if (got.sector !== want.sector)
        report($sformatf("result %0d sector %h, expected %h",
                         results_seen, got.sector, want.sector));
    endtask
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_item   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = CFG_FAT_TYPE;
  logic [31:0] cfg_wdata = '0;

  bit no_idle      = 1'b0;
  int items_sent   = 0;
  int stall_cycles = 0;

  fat_chain_scoreboard sb = new();

  fat_cluster_chain_step_core #(
    .WINDOW_BYTES(WIN_BYTES),
    .SECTOR_BYTES(SEC_BYTES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(0, 99) >= 7);
    if (rst_n && out_valid && out_ready) sb.check_result(out_item);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("** fat_cluster_chain_step_core: FAILED **");
      $finish;
    end
  end

  task automatic send_item(input in_item_t it);
    if (!no_idle && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 40);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic send_lookup(input logic [27:0] clus);
    in_item_t it;
    it.func       = FUNC_LOOKUP;
    it.cluster    = clus;
    it.fill_index = 11'($urandom);
    it.fill_byte  = 8'($urandom);
    send_item(it);
  endtask

  task automatic send_fill(input logic [10:0] idx, input logic [7:0] value);
    in_item_t it;
    it.func       = FUNC_FILL;
    it.cluster    = 28'($urandom);
    it.fill_index = idx;
    it.fill_byte  = value;
    send_item(it);
  endtask

  // A lookup if it misses, fills for the entry's bytes, then the lookup proper.
  task automatic walk_link(input logic [27:0] clus, input logic [27:0] ent,
                           input bit rewrite);
    logic [31:0] image;
    int unsigned idx;
    if (sb.misses(clus)) send_lookup(clus);
    idx   = sb.entry_byte(clus);
    image = $urandom;
    case (sb.entry_width())
      3: begin
        if (sb.nibble_pos(clus) % 2 == 1) image[15:4] = ent[11:0];
        else image[11:0] = ent[11:0];
      end
      4: image[15:0] = ent[15:0];
      default: image[27:0] = ent;
    endcase
    for (int k = 0; k < sb.entry_bytes(); k++) begin
      if (rewrite || !sb.win_loaded[idx + k]) send_fill(11'(idx + k), image[8*k +: 8]);
    end
    send_lookup(clus);
  endtask

  function automatic logic [27:0] pick_start();
    case ($urandom_range(0, 3))
      0: return 28'($urandom);
      1: return 28'(sb.win_base / sb.entry_width() +
                    $urandom_range(0, 2 * WIN_BYTES / sb.entry_width()));
      default: return 28'($urandom_range(0, 32'h3FFFF));
    endcase
  endfunction

  task automatic send_noise();
    in_item_t it;
    it.func       = 1'($urandom_range(0, 1));
    it.cluster    = 28'($urandom);
    it.fill_index = 11'($urandom);
    it.fill_byte  = 8'($urandom);
    if ($urandom_range(0, 1) == 1) it.cluster = pick_start();
    if (it.func == FUNC_LOOKUP && sb.reads_unwritten(it.cluster)) begin
      it.func       = FUNC_FILL;
      it.fill_index = 11'(sb.entry_byte(it.cluster));
    end
    send_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_word(input cfg_idx_t idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic program_regs(input logic [1:0] ft, input logic [28:0] cnt,
                              input logic [31:0] fs, input logic [31:0] ds,
                              input logic [2:0] sh);
    cfg_word(CFG_FAT_TYPE, 32'(ft));
    cfg_word(CFG_CLUS_COUNT, 32'(cnt));
    cfg_word(CFG_FAT_START, fs);
    cfg_word(CFG_DATA_START, ds);
    cfg_word(CFG_CLUS_SHIFT, 32'(sh));
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [27:0]     cur;
    logic [27:0]     ent;
    logic [1:0]      ft;
    logic [28:0]     clusters;
    longint unsigned eoc;
    longint unsigned msk;
    longint unsigned lim;
    int unsigned     roll;
    int              phase_end;
    bit              paused;
    paused = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: FAT16 with no clusters, so only end markers are valid.
    walk_link(28'd0, 28'hFFF8, 1'b1);
    walk_link(28'd1, 28'd5, 1'b0);
    drain();
    // FAT32 at the register extremes; sector sums wrap.
    program_regs(FAT_32, 29'h1000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
    send_lookup(28'd0);
    walk_link(28'hFFF_FFFF, 28'hFFF_FFFF, 1'b1);
    walk_link(28'hFFF_FF00, 28'hFFF_FFF7, 1'b1);
    drain();
    // FAT12 odd entry that ends exactly at the window edge, then one past it.
    program_regs(FAT_12, 29'hFF7, 32'd0, 32'd0, 3'd0);
    send_lookup(28'd683);
    walk_link(28'd2047, 28'hFF6, 1'b1);
    send_lookup(28'd2048);
    drain();
    // The unused type code behaves as FAT32.
    program_regs(FAT_UNUSED, 29'd0, 32'h8000_0000, 32'd1, 3'd3);
    send_lookup(28'h800_0001);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      ft = (ph == 7) ? FAT_UNUSED : 2'(ph % 3);
      case ($urandom_range(0, 9))
        0: clusters = 29'd0;
        1: clusters = 29'h1000_0000;
        2: clusters = 29'd2;
        default: clusters = 29'($urandom_range(2, (ft == FAT_12) ? 32'hFF7 :
                                                  (ft == FAT_16) ? 32'hFFF7 :
                                                  32'h1000_0000));
      endcase
      program_regs(ft, clusters,
                   ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom,
                   ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom,
                   3'($urandom_range(0, 7)));
      no_idle   = (ph == 3);
      phase_end = items_sent + PHASE_ITEMS;
      cur       = pick_start();
      while (items_sent < phase_end) begin
        if (ph == 5 && !paused && items_sent >= phase_end - PHASE_ITEMS / 2) begin
          paused = 1'b1;
          drain();
        end
        if ($urandom_range(0, 99) < 15) begin
          send_noise();
        end else begin
          roll = $urandom_range(0, 99);
          eoc  = sb.eoc_mark();
          msk  = sb.entry_mask();
          lim  = (sb.clus_count < eoc) ? sb.clus_count : eoc;
          if (roll < 55 && lim > 2) begin
            ent = cur + 28'($urandom_range(1, 6));
            if (ent < 2 || ent >= lim) ent = 28'($urandom_range(2, 32'(lim - 1)));
          end else if (roll < 70) begin
            ent = 28'($urandom_range(32'(eoc), 32'(msk)));
          end else if (roll < 85) begin
            if (sb.clus_count < eoc && $urandom_range(0, 1) == 1)
              ent = 28'($urandom_range(32'(sb.clus_count), 32'(eoc - 1)));
            else
              ent = 28'($urandom_range(0, 1));
          end else begin
            ent = 28'($urandom & 32'(msk));
          end
          walk_link(cur, ent, $urandom_range(0, 99) < 40);
          if (sb.last_status == STAT_NEXT && $urandom_range(0, 99) < 85) cur = sb.last_entry;
          else cur = pick_start();
        end
      end
    end
    no_idle = 1'b0;

    drain();
    if (sb.errors == 0) begin
      $display("** fat_cluster_chain_step_core: PASSED **");
    end else begin
      $display("** fat_cluster_chain_step_core: FAILED **");
    end
    $finish;
  end

endmodule
